### rtl/core/esc_pkg.sv
// Shared types and constants for the elevator sweep controller.
// No dependencies; every other file in rtl/core imports this package.
package esc_pkg;

    localparam int NUM_FLOORS = 8;
    localparam int FLOOR_W = $clog2(NUM_FLOORS);
    localparam int DUTY_W = 7;
    localparam logic [DUTY_W-1:0] MAX_DUTY = 7'd100;
    localparam logic [DUTY_W-1:0] DUTY_RESET = 7'd100;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_UP    = 3'd1,
        MODE_DOWN  = 3'd2,
        MODE_DOORS = 3'd3,
        MODE_EMERG = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DN   = 2'd2
    } dir_t;

    typedef enum logic [2:0] {
        EV_TICK      = 3'd0,
        EV_CABIN     = 3'd1,
        EV_HALL_UP   = 3'd2,
        EV_HALL_DOWN = 3'd3,
        EV_ARRIVAL   = 3'd4,
        EV_DOOR_DONE = 3'd5,
        EV_ESTOP     = 3'd6,
        EV_RELEASE   = 3'd7
    } kind_t;

    typedef struct packed {
        mode_t                   ctrl_state;
        dir_t                    travel_dir;
        logic [FLOOR_W-1:0]      at_floor;
        logic [DUTY_W-1:0]       motor_duty;
        logic                    door_timer_start;
        logic [NUM_FLOORS-1:0]   pending_mask;
    } esc_result_t;

endpackage

### rtl/core/esc_if.sv
// Valid/ready channel interfaces for event input and status output.
// Depends on esc_pkg for field widths.
interface esc_in_if
    import esc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic [FLOOR_W-1:0] floor;

    modport source (output valid, output kind, output floor, input ready);
    modport sink (input valid, input kind, input floor, output ready);
endinterface

interface esc_out_if
    import esc_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [2:0]            ctrl_state;
    logic [1:0]            travel_dir;
    logic [FLOOR_W-1:0]    at_floor;
    logic [DUTY_W-1:0]     motor_duty;
    logic                  door_timer_start;
    logic [NUM_FLOORS-1:0] pending_mask;

    modport source (output valid, output ctrl_state, output travel_dir, output at_floor,
                    output motor_duty, output door_timer_start, output pending_mask,
                    input ready);
    modport sink (input valid, input ctrl_state, input travel_dir, input at_floor,
                  input motor_duty, input door_timer_start, input pending_mask,
                  output ready);
endinterface

### rtl/core/esc_target.sv
// Sweep target selection over the outstanding request mask.
// Depends on esc_pkg.
module esc_target
    import esc_pkg::*;
(
    input  logic [NUM_FLOORS-1:0] req,
    input  logic [FLOOR_W-1:0]    cur_floor,
    input  dir_t                  dir,
    output logic [FLOOR_W-1:0]    target
);

    logic [FLOOR_W-1:0] low_up;
    logic               has_up;
    logic [FLOOR_W-1:0] high_below;
    logic               has_below;
    logic [FLOOR_W-1:0] high_at_below;
    logic               has_at_below;
    logic [FLOOR_W-1:0] lowest;
    logic [FLOOR_W-1:0] highest;
    logic [FLOOR_W-1:0] dist_up;
    logic [FLOOR_W-1:0] dist_down;

    always_comb
    begin
        low_up = '0;
        has_up = 1'b0;
        high_below = '0;
        has_below = 1'b0;
        high_at_below = '0;
        has_at_below = 1'b0;
        lowest = '0;
        highest = '0;
        for (int i = NUM_FLOORS - 1; i >= 0; i--)
        begin
            if (req[i] && (FLOOR_W'(i) >= cur_floor))
            begin
                low_up = FLOOR_W'(i);
                has_up = 1'b1;
            end
            if (req[i])
            begin
                lowest = FLOOR_W'(i);
            end
        end
        for (int i = 0; i < NUM_FLOORS; i++)
        begin
            if (req[i] && (FLOOR_W'(i) < cur_floor))
            begin
                high_below = FLOOR_W'(i);
                has_below = 1'b1;
            end
            if (req[i] && (FLOOR_W'(i) <= cur_floor))
            begin
                high_at_below = FLOOR_W'(i);
                has_at_below = 1'b1;
            end
            if (req[i])
            begin
                highest = FLOOR_W'(i);
            end
        end
    end

    assign dist_up = low_up - cur_floor;
    assign dist_down = cur_floor - high_at_below;

    always_comb
    begin
        case (dir)
            DIR_UP:
            begin
                target = has_up ? low_up : highest;
            end
            DIR_DN:
            begin
                if (has_below)
                begin
                    target = high_below;
                end
                else if (req[cur_floor])
                begin
                    target = cur_floor;
                end
                else
                begin
                    target = lowest;
                end
            end
            default:
            begin
                if (has_at_below && (!has_up || dist_down <= dist_up))
                begin
                    target = high_at_below;
                end
                else
                begin
                    target = low_up;
                end
            end
        endcase
    end

endmodule

### rtl/core/esc_core.sv
// Controller state registers and single-pass event/tick update.
// Depends on esc_pkg and esc_target.
module esc_core
    import esc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [DUTY_W-1:0]  cfg_wdata,
    input  logic               push,
    input  logic [2:0]         kind,
    input  logic [FLOOR_W-1:0] floor,
    output esc_result_t        result
);

    logic [DUTY_W-1:0]     run_duty_reg;
    mode_t                 mode_reg, mode_next;
    dir_t                  dir_reg, dir_next;
    logic [FLOOR_W-1:0]    floor_reg, floor_next;
    logic [NUM_FLOORS-1:0] cabin_reg, cabin_next;
    logic [NUM_FLOORS-1:0] hall_up_reg, hall_up_next;
    logic [NUM_FLOORS-1:0] hall_down_reg, hall_down_next;
    logic                  estop_reg, estop_next;
    logic                  door_busy_reg, door_busy_next;
    logic                  arr_pend_reg, arr_pend_next;
    logic [FLOOR_W-1:0]    arr_floor_reg, arr_floor_next;
    logic [DUTY_W-1:0]     duty_reg, duty_next;
    logic                  pulse;

    logic [NUM_FLOORS-1:0] req_all;
    logic [NUM_FLOORS-1:0] floor_sel;
    logic [NUM_FLOORS-1:0] mid_sel;
    logic                  floor_ok;
    mode_t                 mid_mode;
    dir_t                  mid_dir;
    logic [FLOOR_W-1:0]    mid_floor;
    logic                  req_here;
    logic                  req_above;
    logic                  req_below;
    logic                  any_req;
    logic [FLOOR_W-1:0]    target;
    logic [DUTY_W-1:0]     run_duty;

    assign req_all = cabin_reg | hall_up_reg | hall_down_reg;
    assign any_req = |req_all;
    assign floor_ok = (int'(floor) < NUM_FLOORS);
    assign floor_sel = NUM_FLOORS'(1) << floor;
    assign run_duty = (run_duty_reg > MAX_DUTY) ? MAX_DUTY : run_duty_reg;

    assign mid_mode = (mode_reg == MODE_EMERG) ? MODE_IDLE : mode_reg;
    assign mid_dir = (mode_reg == MODE_EMERG) ? DIR_STOP : dir_reg;
    assign mid_floor = arr_pend_reg ? arr_floor_reg : floor_reg;
    assign mid_sel = NUM_FLOORS'(1) << mid_floor;
    assign req_here = req_all[mid_floor];

    always_comb
    begin
        req_above = 1'b0;
        req_below = 1'b0;
        for (int i = 0; i < NUM_FLOORS; i++)
        begin
            if (req_all[i] && (FLOOR_W'(i) > mid_floor))
            begin
                req_above = 1'b1;
            end
            if (req_all[i] && (FLOOR_W'(i) < mid_floor))
            begin
                req_below = 1'b1;
            end
        end
    end

    esc_target u_target (
        .req       (req_all),
        .cur_floor (mid_floor),
        .dir       (mid_dir),
        .target    (target)
    );

    always_comb
    begin
        mode_next = mode_reg;
        dir_next = dir_reg;
        floor_next = floor_reg;
        cabin_next = cabin_reg;
        hall_up_next = hall_up_reg;
        hall_down_next = hall_down_reg;
        estop_next = estop_reg;
        door_busy_next = door_busy_reg;
        arr_pend_next = arr_pend_reg;
        arr_floor_next = arr_floor_reg;
        duty_next = duty_reg;
        pulse = 1'b0;
        case (kind_t'(kind))
            EV_TICK:
            begin
                if (estop_reg)
                begin
                    if (mode_reg != MODE_EMERG)
                    begin
                        duty_next = '0;
                        mode_next = MODE_EMERG;
                        dir_next = DIR_STOP;
                    end
                end
                else
                begin
                    mode_next = mid_mode;
                    dir_next = mid_dir;
                    floor_next = mid_floor;
                    arr_pend_next = 1'b0;
                    if (arr_pend_reg && req_here)
                    begin
                        duty_next = '0;
                        cabin_next = cabin_reg & ~mid_sel;
                        hall_up_next = hall_up_reg & ~mid_sel;
                        hall_down_next = hall_down_reg & ~mid_sel;
                        mode_next = MODE_DOORS;
                        door_busy_next = 1'b1;
                        pulse = 1'b1;
                    end
                    else
                    begin
                        case (mid_mode)
                            MODE_IDLE:
                            begin
                                if (any_req)
                                begin
                                    if (target == mid_floor)
                                    begin
                                        cabin_next = cabin_reg & ~mid_sel;
                                        hall_up_next = hall_up_reg & ~mid_sel;
                                        hall_down_next = hall_down_reg & ~mid_sel;
                                        mode_next = MODE_DOORS;
                                        door_busy_next = 1'b1;
                                        pulse = 1'b1;
                                    end
                                    else if (target > mid_floor)
                                    begin
                                        dir_next = DIR_UP;
                                        mode_next = MODE_UP;
                                        duty_next = run_duty;
                                    end
                                    else
                                    begin
                                        dir_next = DIR_DN;
                                        mode_next = MODE_DOWN;
                                        duty_next = run_duty;
                                    end
                                end
                            end
                            MODE_UP:
                            begin
                                if (!req_above && !req_here)
                                begin
                                    if (req_below)
                                    begin
                                        dir_next = DIR_DN;
                                        mode_next = MODE_DOWN;
                                    end
                                    else
                                    begin
                                        duty_next = '0;
                                        dir_next = DIR_STOP;
                                        mode_next = MODE_IDLE;
                                    end
                                end
                            end
                            MODE_DOWN:
                            begin
                                if (!req_below && !req_here)
                                begin
                                    if (req_above)
                                    begin
                                        dir_next = DIR_UP;
                                        mode_next = MODE_UP;
                                    end
                                    else
                                    begin
                                        duty_next = '0;
                                        dir_next = DIR_STOP;
                                        mode_next = MODE_IDLE;
                                    end
                                end
                            end
                            MODE_DOORS:
                            begin
                                if (!door_busy_reg)
                                begin
                                    if (any_req && (target > mid_floor))
                                    begin
                                        dir_next = DIR_UP;
                                        mode_next = MODE_UP;
                                        duty_next = run_duty;
                                    end
                                    else if (any_req && (target < mid_floor))
                                    begin
                                        dir_next = DIR_DN;
                                        mode_next = MODE_DOWN;
                                        duty_next = run_duty;
                                    end
                                    else
                                    begin
                                        dir_next = DIR_STOP;
                                        mode_next = MODE_IDLE;
                                    end
                                end
                            end
                            default:
                            begin
                                mode_next = mid_mode;
                            end
                        endcase
                    end
                end
            end
            EV_CABIN:
            begin
                if (floor_ok)
                begin
                    cabin_next = cabin_reg | floor_sel;
                end
            end
            EV_HALL_UP:
            begin
                if (floor_ok)
                begin
                    hall_up_next = hall_up_reg | floor_sel;
                end
            end
            EV_HALL_DOWN:
            begin
                if (floor_ok)
                begin
                    hall_down_next = hall_down_reg | floor_sel;
                end
            end
            EV_ARRIVAL:
            begin
                if (floor_ok)
                begin
                    arr_pend_next = 1'b1;
                    arr_floor_next = floor;
                end
            end
            EV_DOOR_DONE:
            begin
                door_busy_next = 1'b0;
            end
            EV_ESTOP:
            begin
                estop_next = 1'b1;
            end
            default:
            begin
                estop_next = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        result.ctrl_state = mode_next;
        result.travel_dir = dir_next;
        result.at_floor = floor_next;
        result.motor_duty = duty_next;
        result.door_timer_start = pulse;
        result.pending_mask = cabin_next | hall_up_next | hall_down_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_duty_reg <= DUTY_RESET;
        end
        else if (cfg_we)
        begin
            run_duty_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            dir_reg <= DIR_STOP;
            floor_reg <= '0;
            cabin_reg <= '0;
            hall_up_reg <= '0;
            hall_down_reg <= '0;
            estop_reg <= 1'b0;
            door_busy_reg <= 1'b0;
            arr_pend_reg <= 1'b0;
            arr_floor_reg <= '0;
            duty_reg <= '0;
        end
        else if (push)
        begin
            mode_reg <= mode_next;
            dir_reg <= dir_next;
            floor_reg <= floor_next;
            cabin_reg <= cabin_next;
            hall_up_reg <= hall_up_next;
            hall_down_reg <= hall_down_next;
            estop_reg <= estop_next;
            door_busy_reg <= door_busy_next;
            arr_pend_reg <= arr_pend_next;
            arr_floor_reg <= arr_floor_next;
            duty_reg <= duty_next;
        end
    end

endmodule

### rtl/core/esc_out_buf.sv
// Output register with one skid entry for status results.
// Depends on esc_pkg.
module esc_out_buf
    import esc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  esc_result_t push_data,
    output logic        push_ready,
    output logic        out_valid,
    input  logic        out_ready,
    output esc_result_t out_data
);

    logic        out_valid_reg, out_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    esc_result_t out_data_reg, out_data_next;
    esc_result_t skid_data_reg, skid_data_next;
    logic        pop;

    assign pop = out_valid_reg && out_ready;
    assign push_ready = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next = out_data_reg;
        skid_data_next = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_next = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push && (!out_valid_reg || pop))
        begin
            out_data_next = push_data;
            out_valid_next = 1'b1;
        end
        else if (push)
        begin
            skid_data_next = push_data;
            skid_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

### rtl/core/elevator_sweep_controller.sv
// Elevator sweep controller: one status result per event, one event per cycle.
// Depends on esc_pkg, esc_if, esc_core and esc_out_buf.
// Each event is decoded and applied to the controller state in the cycle it
// transfers; its status is registered at that edge, in the output register or,
// if that holds a result not yet taken, in the one-entry skid behind it. The
// target search is a priority and distance compare over the request masks in
// that same cycle, so a new event can transfer every cycle while input ready
// is high. The skid keeps input ready high while one result waits; ready drops
// only when two results are held. The user writes motor_run_duty only while
// idle, via cfg_we/cfg_wdata (not enforced); values above 100 apply as 100.
module elevator_sweep_controller
    import esc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [DUTY_W-1:0] cfg_wdata,
    esc_in_if.sink            req_ch,
    esc_out_if.source         rsp_ch
);

    logic        push;
    logic        push_ready;
    esc_result_t result;
    esc_result_t out_data;

    assign push = req_ch.valid && push_ready;
    assign req_ch.ready = push_ready;

    esc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .push      (push),
        .kind      (req_ch.kind),
        .floor     (req_ch.floor),
        .result    (result)
    );

    esc_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (result),
        .push_ready (push_ready),
        .out_valid  (rsp_ch.valid),
        .out_ready  (rsp_ch.ready),
        .out_data   (out_data)
    );

    assign rsp_ch.ctrl_state = out_data.ctrl_state;
    assign rsp_ch.travel_dir = out_data.travel_dir;
    assign rsp_ch.at_floor = out_data.at_floor;
    assign rsp_ch.motor_duty = out_data.motor_duty;
    assign rsp_ch.door_timer_start = out_data.door_timer_start;
    assign rsp_ch.pending_mask = out_data.pending_mask;

endmodule

### rtl/core/esc_checker.sv
// Port-level checks on the status channel, bound to the top level.
// Depends on esc_pkg and elevator_sweep_controller.
module esc_checker
    import esc_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic [2:0]        ctrl_state,
    input logic [1:0]        travel_dir,
    input logic [DUTY_W-1:0] motor_duty,
    input logic              door_timer_start
);

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(ctrl_state)
            && $stable(motor_duty))
        else $error("stalled transfer changed");

    a_stopped_modes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (ctrl_state == MODE_IDLE || ctrl_state == MODE_EMERG
            || ctrl_state == MODE_DOORS) |-> motor_duty == '0)
        else $error("motor running while stopped");

    a_emerg_dir: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (ctrl_state == MODE_EMERG || ctrl_state == MODE_IDLE)
            |-> travel_dir == DIR_STOP)
        else $error("direction set while idle or in emergency");

    a_moving_dir: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (ctrl_state == MODE_UP || ctrl_state == MODE_DOWN)
            |-> travel_dir == ctrl_state[1:0])
        else $error("direction disagrees with travel mode");

    a_timer_doors: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && door_timer_start |-> ctrl_state == MODE_DOORS)
        else $error("door timer start outside doors open");

endmodule

bind elevator_sweep_controller esc_checker u_esc_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (rsp_ch.valid),
    .out_ready        (rsp_ch.ready),
    .ctrl_state       (rsp_ch.ctrl_state),
    .travel_dir       (rsp_ch.travel_dir),
    .motor_duty       (rsp_ch.motor_duty),
    .door_timer_start (rsp_ch.door_timer_start)
);

### tb/esc_status_check.sv
`timescale 1ns / 1ps
// Status predictor and comparator for the elevator sweep controller bench.
// Depends on esc_pkg and the esc_in_if / esc_out_if channel interfaces.
module esc_status_check
    import esc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [DUTY_W-1:0] cfg_wdata,
    esc_in_if                 in_mon,
    esc_out_if                out_mon,
    output int                fail_count,
    output int                results_owed
);

    mode_t                 mode_q;
    dir_t                  dir_q;
    logic [FLOOR_W-1:0]    floor_q;
    logic [NUM_FLOORS-1:0] cabin_q;
    logic [NUM_FLOORS-1:0] hall_up_q;
    logic [NUM_FLOORS-1:0] hall_dn_q;
    logic                  estop_q;
    logic                  door_busy_q;
    logic                  arrival_q;
    logic [FLOOR_W-1:0]    arrival_floor_q;
    logic [DUTY_W-1:0]     duty_q;
    logic [DUTY_W-1:0]     run_duty_setting;
    logic                  timer_pulse;

    esc_result_t           status_queue[$];

    function automatic logic [NUM_FLOORS-1:0] all_requests();
        return cabin_q | hall_up_q | hall_dn_q;
    endfunction

    function automatic logic request_here();
        logic [NUM_FLOORS-1:0] r;
        r = all_requests();
        return r[floor_q];
    endfunction

    function automatic logic request_above();
        logic [NUM_FLOORS-1:0] r;
        r = all_requests();
        return (r >> (int'(floor_q) + 1)) != '0;
    endfunction

    function automatic logic request_below();
        logic [NUM_FLOORS-1:0] r;
        logic [NUM_FLOORS-1:0] below;
        r = all_requests();
        below = (NUM_FLOORS'(1) << floor_q) - NUM_FLOORS'(1);
        return (r & below) != '0;
    endfunction

    function automatic logic [DUTY_W-1:0] moving_duty();
        return (run_duty_setting > MAX_DUTY) ? MAX_DUTY : run_duty_setting;
    endfunction

    // Sweep in the travel direction; with none, nearest floor wins, lower on a tie.
    function automatic logic pick_target(output logic [FLOOR_W-1:0] tgt);
        logic [NUM_FLOORS-1:0] r;
        int best_dist;
        int span;
        r = all_requests();
        tgt = '0;
        best_dist = 255;
        if (r == '0)
            return 1'b0;
        if (dir_q == DIR_UP)
        begin
            for (int f = floor_q; f < NUM_FLOORS; f++)
                if (r[f])
                begin
                    tgt = FLOOR_W'(f);
                    return 1'b1;
                end
            for (int f = NUM_FLOORS - 1; f >= 0; f--)
                if (r[f])
                begin
                    tgt = FLOOR_W'(f);
                    return 1'b1;
                end
            return 1'b0;
        end
        if (dir_q == DIR_DN)
        begin
            for (int f = int'(floor_q) - 1; f >= 0; f--)
                if (r[f])
                begin
                    tgt = FLOOR_W'(f);
                    return 1'b1;
                end
            if (r[floor_q])
            begin
                tgt = floor_q;
                return 1'b1;
            end
            for (int f = 0; f < NUM_FLOORS; f++)
                if (r[f])
                begin
                    tgt = FLOOR_W'(f);
                    return 1'b1;
                end
            return 1'b0;
        end
        for (int f = 0; f < NUM_FLOORS; f++)
            if (r[f])
            begin
                span = (f > int'(floor_q)) ? f - int'(floor_q) : int'(floor_q) - f;
                if (span < best_dist)
                begin
                    best_dist = span;
                    tgt = FLOOR_W'(f);
                end
            end
        return 1'b1;
    endfunction

    task automatic open_doors();
        cabin_q[floor_q]   = 1'b0;
        hall_up_q[floor_q] = 1'b0;
        hall_dn_q[floor_q] = 1'b0;
        mode_q             = MODE_DOORS;
        door_busy_q        = 1'b1;
        timer_pulse        = 1'b1;
    endtask

    task automatic start_moving(input dir_t d);
        dir_q  = d;
        mode_q = (d == DIR_UP) ? MODE_UP : MODE_DOWN;
        duty_q = moving_duty();
    endtask

    task automatic stop_idle();
        duty_q = '0;
        dir_q  = DIR_STOP;
        mode_q = MODE_IDLE;
    endtask

    task automatic run_tick();
        logic [FLOOR_W-1:0] tgt;
        logic               found;
        if (estop_q)
        begin
            if (mode_q != MODE_EMERG)
            begin
                duty_q = '0;
                mode_q = MODE_EMERG;
                dir_q  = DIR_STOP;
            end
            return;
        end
        if (mode_q == MODE_EMERG)
        begin
            mode_q = MODE_IDLE;
            dir_q  = DIR_STOP;
        end
        if (arrival_q)
        begin
            arrival_q = 1'b0;
            floor_q   = arrival_floor_q;
            if (request_here())
            begin
                duty_q = '0;
                open_doors();
                return;
            end
        end
        case (mode_q)
            MODE_IDLE:
            begin
                found = pick_target(tgt);
                if (found)
                begin
                    if (tgt == floor_q)
                        open_doors();
                    else if (tgt > floor_q)
                        start_moving(DIR_UP);
                    else
                        start_moving(DIR_DN);
                end
            end
            MODE_UP:
            begin
                // reverse keeps the current duty
                if (!request_above() && !request_here())
                begin
                    if (request_below())
                    begin
                        dir_q  = DIR_DN;
                        mode_q = MODE_DOWN;
                    end
                    else
                        stop_idle();
                end
            end
            MODE_DOWN:
            begin
                if (!request_below() && !request_here())
                begin
                    if (request_above())
                    begin
                        dir_q  = DIR_UP;
                        mode_q = MODE_UP;
                    end
                    else
                        stop_idle();
                end
            end
            MODE_DOORS:
            begin
                if (!door_busy_q)
                begin
                    found = pick_target(tgt);
                    if (found && tgt > floor_q)
                        start_moving(DIR_UP);
                    else if (found && tgt < floor_q)
                        start_moving(DIR_DN);
                    else
                    begin
                        dir_q  = DIR_STOP;
                        mode_q = MODE_IDLE;
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic apply_event(input kind_t k, input logic [FLOOR_W-1:0] f,
                               output esc_result_t status);
        logic in_range;
        in_range    = int'(f) < NUM_FLOORS;
        timer_pulse = 1'b0;
        case (k)
            EV_TICK:      run_tick();
            EV_CABIN:     if (in_range) cabin_q[f] = 1'b1;
            EV_HALL_UP:   if (in_range) hall_up_q[f] = 1'b1;
            EV_HALL_DOWN: if (in_range) hall_dn_q[f] = 1'b1;
            EV_ARRIVAL:
            begin
                if (in_range)
                begin
                    arrival_q       = 1'b1;
                    arrival_floor_q = f;
                end
            end
            EV_DOOR_DONE: door_busy_q = 1'b0;
            EV_ESTOP:     estop_q = 1'b1;
            default:      estop_q = 1'b0;
        endcase
        status.ctrl_state       = mode_q;
        status.travel_dir       = dir_q;
        status.at_floor         = floor_q;
        status.motor_duty       = duty_q;
        status.door_timer_start = timer_pulse;
        status.pending_mask     = all_requests();
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] status check: %s", $time, msg);
        fail_count++;
    endtask

    task automatic compare_status(input esc_result_t want);
        if (out_mon.ctrl_state !== want.ctrl_state)
            report_mismatch($sformatf("ctrl_state got %0d want %0d",
                                      out_mon.ctrl_state, want.ctrl_state));
        if (out_mon.travel_dir !== want.travel_dir)
            report_mismatch($sformatf("travel_dir got %0d want %0d",
                                      out_mon.travel_dir, want.travel_dir));
        if (out_mon.at_floor !== want.at_floor)
            report_mismatch($sformatf("at_floor got %0d want %0d",
                                      out_mon.at_floor, want.at_floor));
        if (out_mon.motor_duty !== want.motor_duty)
            report_mismatch($sformatf("motor_duty got %0d want %0d",
                                      out_mon.motor_duty, want.motor_duty));
        if (out_mon.door_timer_start !== want.door_timer_start)
            report_mismatch($sformatf("door_timer_start got %0d want %0d",
                                      out_mon.door_timer_start, want.door_timer_start));
        if (out_mon.pending_mask !== want.pending_mask)
            report_mismatch($sformatf("pending_mask got %02h want %02h",
                                      out_mon.pending_mask, want.pending_mask));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        esc_result_t status;
        if (!rst_n)
        begin
            mode_q           = MODE_IDLE;
            dir_q            = DIR_STOP;
            floor_q          = '0;
            cabin_q          = '0;
            hall_up_q        = '0;
            hall_dn_q        = '0;
            estop_q          = 1'b0;
            door_busy_q      = 1'b0;
            arrival_q        = 1'b0;
            arrival_floor_q  = '0;
            duty_q           = '0;
            run_duty_setting = DUTY_RESET;
            timer_pulse      = 1'b0;
            status_queue.delete();
            results_owed     = 0;
        end
        else
        begin
            if (cfg_we)
                run_duty_setting = cfg_wdata;
            if (out_mon.valid && out_mon.ready)
            begin
                if (status_queue.size() == 0)
                    report_mismatch("result transfer with nothing expected");
                else
                    compare_status(status_queue.pop_front());
            end
            if (in_mon.valid && in_mon.ready)
            begin
                apply_event(kind_t'(in_mon.kind), in_mon.floor, status);
                status_queue.push_back(status);
            end
            results_owed = status_queue.size();
        end
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// Top of the elevator sweep controller bench: clock, reset, event stimulus and verdict.
// Depends on esc_pkg, esc_if, the controller RTL and esc_status_check.
module tb_top;
    import esc_pkg::*;

    localparam int PHASE_COUNT  = 6;
    localparam int PHASE_ITEMS  = 150;
    localparam int QUIET_LIMIT  = 2000;
    localparam int SETTLE_TICKS = 4;
    localparam int DRAIN_TICKS  = 8;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [DUTY_W-1:0] cfg_wdata = '0;

    int                fail_count;
    int                results_owed;
    int                quiet_cycles = 0;
    int                ready_left = 0;
    logic              ready_level = 1'b0;
    bit                idle_on = 1'b1;
    logic [FLOOR_W-1:0] last_request_floor = '0;

    esc_in_if  req_ch();
    esc_out_if rsp_ch();

    elevator_sweep_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req_ch    (req_ch),
        .rsp_ch    (rsp_ch)
    );

    esc_status_check u_status_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_mon       (req_ch),
        .out_mon      (rsp_ch),
        .fail_count   (fail_count),
        .results_owed (results_owed)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        req_ch.valid = 1'b0;
        req_ch.kind  = EV_TICK;
        req_ch.floor = '0;
        rsp_ch.ready = 1'b0;
    end

    // Receiver: alternate ready bursts with stall bursts while idling is on.
    always @(negedge clk)
    begin
        if (!idle_on)
        begin
            ready_level = 1'b1;
            ready_left  = 0;
        end
        else if (ready_left == 0)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                ready_level = 1'b0;
                ready_left  = $urandom_range(1, 17);
            end
            else
            begin
                ready_level = 1'b1;
                ready_left  = $urandom_range(1, 24);
            end
        end
        else
            ready_left--;
        rsp_ch.ready <= ready_level;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Called right after a falling edge; returns right after the falling edge
    // that follows the transfer.
    task automatic send_event(input kind_t k, input logic [FLOOR_W-1:0] f);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 17);
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.kind  <= k;
        req_ch.floor <= f;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
    endtask

    task automatic send_random_event();
        int                 pick;
        kind_t              k;
        logic [FLOOR_W-1:0] f;
        pick = $urandom_range(0, 99);
        f    = FLOOR_W'($urandom_range(0, NUM_FLOORS - 1));
        if (pick < 38)
            k = EV_TICK;
        else if (pick < 58)
        begin
            k = kind_t'($urandom_range(EV_CABIN, EV_HALL_DOWN));
            last_request_floor = f;
        end
        else if (pick < 75)
        begin
            k = EV_ARRIVAL;
            // favor floors with a request so stops happen often
            if ($urandom_range(0, 1) == 0)
                f = last_request_floor;
        end
        else if (pick < 90)
            k = EV_DOOR_DONE;
        else if (pick < 93)
            k = EV_ESTOP;
        else
            k = EV_RELEASE;
        send_event(k, f);
    endtask

    task automatic write_run_duty(input logic [DUTY_W-1:0] value);
        req_ch.valid <= 1'b0;
        while (results_owed != 0)
            @(negedge clk);
        repeat (SETTLE_TICKS) @(negedge clk);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        logic [DUTY_W-1:0] duty_plan [PHASE_COUNT];
        duty_plan = '{7'd0, 7'd127, 7'd100, 7'd1, 7'd101, 7'd64};
        duty_plan[PHASE_COUNT-1] = DUTY_W'($urandom_range(2, 99));

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_event(EV_TICK, 3'd0);
        send_event(EV_CABIN, 3'd7);
        send_event(EV_TICK, 3'd5);
        send_event(EV_HALL_DOWN, 3'd2);
        send_event(EV_ARRIVAL, 3'd7);
        send_event(EV_TICK, 3'd0);
        send_event(EV_TICK, 3'd0);
        send_event(EV_DOOR_DONE, 3'd0);
        send_event(EV_TICK, 3'd0);
        send_event(EV_ARRIVAL, 3'd1);
        send_event(EV_TICK, 3'd0);
        send_event(EV_HALL_UP, 3'd0);
        send_event(EV_HALL_UP, 3'd3);
        send_event(EV_ESTOP, 3'd0);
        send_event(EV_TICK, 3'd0);
        send_event(EV_ARRIVAL, 3'd3);
        send_event(EV_TICK, 3'd0);
        send_event(EV_RELEASE, 3'd0);
        send_event(EV_TICK, 3'd0);
        send_event(EV_TICK, 3'd0);
        send_event(EV_DOOR_DONE, 3'd0);
        send_event(EV_TICK, 3'd0);
        send_event(EV_ARRIVAL, 3'd0);
        send_event(EV_TICK, 3'd0);
        send_event(EV_DOOR_DONE, 3'd0);
        send_event(EV_TICK, 3'd0);
        send_event(EV_DOOR_DONE, 3'd7);

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            write_run_duty(duty_plan[p]);
            idle_on = (p == PHASE_COUNT - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
            repeat (PHASE_ITEMS) send_random_event();
        end

        req_ch.valid <= 1'b0;
        while (results_owed != 0)
            @(negedge clk);
        repeat (DRAIN_TICKS) @(negedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
